[rtl/core/baro_pkg.sv]
// Package: item types, register indexes, constants and helpers for the baro compensation core.
`default_nettype none
package baro_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEMP    = 2'd0;
    localparam logic [1:0] CFG_PRESS_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_9 = 2'd3;

    localparam logic [19:0] RAW_SKIP     = 20'h80000;
    localparam logic [31:0] FINE_OFFSET  = 32'd64000;
    localparam logic [31:0] PRESS_BASE   = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;
    localparam logic [31:0] HALF_RANGE   = 32'h8000_0000;
    localparam logic [31:0] P1_OFFSET    = 32'd32768;
    localparam logic [31:0] TEMP_ROUND   = 32'd128;
    localparam int          DIV_STAGES   = 32;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_pascal;
        logic               reading_valid;
    } t_out_item;

    // One restoring-division stage
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
    } t_div;

    // Arithmetic right shift of a 32-bit pattern
    function automatic logic [31:0] sar(input logic [31:0] x, input int unsigned s);
        return 32'($signed(x) >>> s);
    endfunction

    // Sign-extend a 16-bit coefficient
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // One quotient bit: shift in the next numerator bit, subtract if it fits
    function automatic t_div div_step(input t_div d, input logic [31:0] den);
        t_div        r;
        logic [32:0] trial;
        trial = {d.rem, d.num[31]};
        r.num = {d.num[30:0], 1'b0};
        if (trial >= {1'b0, den}) begin
            r.rem = 32'(trial - {1'b0, den});
            r.quo = {d.quo[30:0], 1'b1};
        end else begin
            r.rem = trial[31:0];
            r.quo = {d.quo[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/baro_sensor_compensation_top.sv]
// Top level: pipelined barometric temperature and pressure compensation.
//
// Input channel: i_in_valid / o_in_stall carry one item (raw temperature and
// raw pressure). Output channel: o_out_valid / i_out_stall carry one result
// item (temperature in 0.01 degC, pressure in Pa, reading valid flag).
// Configuration: i_cfg_we with i_cfg_idx and i_cfg_data writes a calibration
// register (0 temp coeffs, 1 and 2 pressure coeffs, 3 P9); write while idle.
// Throughput: one item per cycle while the output is not stalled. Stages before
// the pressure divider hold the multiplies of both formulas; the divider is a
// load register plus stages of one quotient bit each; the stages after it hold
// the final pressure correction.
// Every stage holds a valid bit; the whole pipeline advances whenever the
// output register is empty or being taken. While the receiver stalls a held
// result, the pipeline freezes and o_in_stall is raised; nothing is lost.
// Reset (synchronous, active low) clears all valid bits and the calibration
// registers to zero.
`default_nettype none
module baro_sensor_compensation_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire baro_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output baro_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [63:0]         i_cfg_data
);

    localparam int ND = baro_pkg::DIV_STAGES;

    // Calibration registers
    logic [47:0] r_tc;
    logic [63:0] r_pa;
    logic [63:0] r_pb;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pa <= '0;
            r_pb <= '0;
            r_p9 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                baro_pkg::CFG_TEMP:    r_tc <= i_cfg_data[47:0];
                baro_pkg::CFG_PRESS_A: r_pa <= i_cfg_data;
                baro_pkg::CFG_PRESS_B: r_pb <= i_cfg_data;
                baro_pkg::CFG_PRESS_9: r_p9 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_tc[15:0]};
    assign t2 = baro_pkg::sx16(r_tc[31:16]);
    assign t3 = baro_pkg::sx16(r_tc[47:32]);
    assign p1 = {16'd0, r_pa[15:0]};
    assign p2 = baro_pkg::sx16(r_pa[31:16]);
    assign p3 = baro_pkg::sx16(r_pa[47:32]);
    assign p4 = baro_pkg::sx16(r_pa[63:48]);
    assign p5 = baro_pkg::sx16(r_pb[15:0]);
    assign p6 = baro_pkg::sx16(r_pb[31:16]);
    assign p7 = baro_pkg::sx16(r_pb[47:32]);
    assign p8 = baro_pkg::sx16(r_pb[63:48]);
    assign p9 = baro_pkg::sx16(r_p9);

    // Global advance: output empty or being taken
    logic adv;
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    // Stage valid bits
    logic [11:0] r_v;
    logic [ND:0] r_dv;
    logic [2:0]  r_ve;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_dv        <= '0;
            r_ve        <= '0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_v         <= {r_v[10:0], i_in_valid};
            r_dv        <= {r_dv[ND-1:0], r_v[11]};
            r_ve        <= {r_ve[1:0], r_dv[ND]};
            o_out_valid <= r_ve[2];
        end
    end

    // Payload registers
    logic [19:0] r0_at, r0_ap, r1_ap, r2_ap, r3_ap, r4_ap, r5_ap, r6_ap, r7_ap, r8_ap, r9_ap;
    logic [11:0] r_skip;
    logic [31:0] r1_d1, r1_b0, r2_m1, r2_bb, r3_at, r3_bs, r4_fine;
    logic [31:0] r5_temp, r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp;
    logic [31:0] r5_pa, r5_q, r6_qq, r6_ap5, r6_p2a, r7_b1, r7_q13, r7_ap5, r7_p2a;
    logic [31:0] r8_b2, r8_a2, r9_a3m, r9_b2, r10_a3, r10_nb, r11_prm, r11_a3;
    baro_pkg::t_div r_dd [0:ND];
    logic [31:0] r_dden [0:ND-1];
    logic [31:0] r_dtemp [0:ND];
    logic [ND:0] r_dskip, r_dzero, r_ddbl;
    logic [31:0] re1_pr, re2_pr, re3_pr, re1_temp, re2_temp, re3_temp;
    logic [31:0] re2_xx, re2_pr8, re3_a9, re3_b8;
    logic [2:0]  re_skip, re_zero;

    logic [31:0] fine_half, pa_w, a3_w, num_w, pr_w, out_pr;
    assign fine_half = baro_pkg::sar(r4_fine, 1) - baro_pkg::FINE_OFFSET;
    assign pa_w      = fine_half;
    assign a3_w      = baro_pkg::sar(r9_a3m, 15);
    assign num_w     = (r11_prm < baro_pkg::HALF_RANGE) ? {r11_prm[30:0], 1'b0} : r11_prm;
    assign pr_w      = r_ddbl[ND] ? r_dd[ND].quo : {r_dd[ND].quo[30:0], 1'b0};
    assign out_pr    = re3_pr + baro_pkg::sar(baro_pkg::sar(re3_a9, 12) + re3_b8 + p7, 4);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // Input capture and skipped-conversion check
            r0_at     <= i_in_item.raw_temperature;
            r0_ap     <= i_in_item.raw_pressure;
            r_skip[0] <= (i_in_item.raw_temperature == 20'd0)
                      || (i_in_item.raw_temperature == baro_pkg::RAW_SKIP)
                      || (i_in_item.raw_pressure == baro_pkg::RAW_SKIP);
            r_skip[11:1] <= r_skip[10:0];
            r1_ap <= r0_ap; r2_ap <= r1_ap; r3_ap <= r2_ap; r4_ap <= r3_ap;
            r5_ap <= r4_ap; r6_ap <= r5_ap; r7_ap <= r6_ap; r8_ap <= r7_ap;
            r9_ap <= r8_ap;

            // Temperature formula
            r1_d1   <= {15'd0, r0_at[19:3]} - {t1[30:0], 1'b0};
            r1_b0   <= {16'd0, r0_at[19:4]} - t1;
            r2_m1   <= r1_d1 * t2;
            r2_bb   <= r1_b0 * r1_b0;
            r3_at   <= baro_pkg::sar(r2_m1, 11);
            r3_bs   <= baro_pkg::sar(r2_bb, 12) * t3;
            r4_fine <= r3_at + baro_pkg::sar(r3_bs, 14);
            r5_temp <= baro_pkg::sar({r4_fine[29:0], 2'b00} + r4_fine
                                     + baro_pkg::TEMP_ROUND, 8);
            r6_temp <= r5_temp; r7_temp <= r6_temp; r8_temp <= r7_temp;
            r9_temp <= r8_temp; r10_temp <= r9_temp; r11_temp <= r10_temp;

            // Pressure: divisor and numerator
            r5_pa   <= pa_w;
            r5_q    <= baro_pkg::sar(pa_w, 2);
            r6_qq   <= r5_q * r5_q;
            r6_ap5  <= r5_pa * p5;
            r6_p2a  <= p2 * r5_pa;
            r7_b1   <= baro_pkg::sar(r6_qq, 11) * p6;
            r7_q13  <= p3 * baro_pkg::sar(r6_qq, 13);
            r7_ap5  <= r6_ap5;
            r7_p2a  <= r6_p2a;
            r8_b2   <= baro_pkg::sar(r7_b1 + {r7_ap5[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
            r8_a2   <= baro_pkg::sar(baro_pkg::sar(r7_q13, 3)
                                     + baro_pkg::sar(r7_p2a, 1), 18);
            r9_a3m  <= (baro_pkg::P1_OFFSET + r8_a2) * p1;
            r9_b2   <= r8_b2;
            r10_a3  <= a3_w;
            r10_nb  <= (baro_pkg::PRESS_BASE - {12'd0, r9_ap}) - baro_pkg::sar(r9_b2, 12);
            r11_prm <= r10_nb * baro_pkg::PRESS_SCALE;
            r11_a3  <= r10_a3;

            // Divider load
            r_dd[0]      <= '{rem: 32'd0, num: num_w, quo: 32'd0};
            r_dden[0]    <= r11_a3;
            r_dtemp[0]   <= r11_temp;
            r_dskip[0]   <= r_skip[11];
            r_dzero[0]   <= (r11_a3 == 32'd0);
            r_ddbl[0]    <= (r11_prm < baro_pkg::HALF_RANGE);

            // Divider stages, one quotient bit each
            for (int k = 0; k < ND; k++) begin
                r_dd[k+1]    <= baro_pkg::div_step(r_dd[k], r_dden[k]);
                r_dtemp[k+1] <= r_dtemp[k];
            end
            for (int k = 0; k < ND - 1; k++) begin
                r_dden[k+1]  <= r_dden[k];
            end
            r_dskip[ND:1] <= r_dskip[ND-1:0];
            r_dzero[ND:1] <= r_dzero[ND-1:0];
            r_ddbl[ND:1]  <= r_ddbl[ND-1:0];

            // Final correction
            re1_pr   <= pr_w;
            re1_temp <= r_dtemp[ND];
            re2_pr   <= re1_pr;
            re2_temp <= re1_temp;
            re2_xx   <= {3'd0, re1_pr[31:3]} * {3'd0, re1_pr[31:3]};
            re2_pr8  <= {2'd0, re1_pr[31:2]} * p8;
            re3_pr   <= re2_pr;
            re3_temp <= re2_temp;
            re3_a9   <= p9 * {13'd0, re2_xx[31:13]};
            re3_b8   <= baro_pkg::sar(re2_pr8, 13);
            re_skip  <= {re_skip[1:0], r_dskip[ND]};
            re_zero  <= {re_zero[1:0], r_dzero[ND]};

            // Output register
            if (re_skip[2]) begin
                o_out_item <= '0;
            end else begin
                o_out_item.temperature_centi <= re3_temp;
                o_out_item.pressure_pascal   <= re_zero[2] ? 32'd0 : out_pr;
                o_out_item.reading_valid     <= 1'b1;
            end
        end
    end

    // A skipped reading reports zeros
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.reading_valid) |->
        (o_out_item.pressure_pascal == 32'd0 && o_out_item.temperature_centi == 32'sd0))
        else $error("skipped reading with nonzero result");

    // Pipeline freezes while the output is held
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_v) && $stable(r_dv) && $stable(r_ve)))
        else $error("pipeline moved during output stall");

    // An accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v[0])
        else $error("accepted item lost at entry");

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Testbench for the barometric compensation core: directed and random readings checked
// against an in-bench predictor of the 32-bit integer compensation formulas.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT    = 48;
    localparam int WDOG_LIMIT  = 20000;
    localparam int RAND_ITEMS  = 950;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    baro_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    baro_pkg::t_out_item o_out_item;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_idx = '0;
    logic [63:0]         i_cfg_data = '0;

    baro_sensor_compensation_top dut (.*);

    always #5 i_clk = ~i_clk;

    // calibration shadow
    logic [47:0] cal_temp;
    logic [63:0] cal_pa, cal_pb;
    logic [15:0] cal_p9;

    baro_pkg::t_in_item  reading_q[$];
    baro_pkg::t_out_item expected_q[$];
    int        err_count = 0;
    int        idle_cycles = 0;
    bit        stim_done = 1'b0;

    function automatic logic [31:0] asr(input logic [31:0] x, input int s);
        return 32'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sext(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // compensated temperature and pressure for one reading
    function automatic baro_pkg::t_out_item compensate(input baro_pkg::t_in_item it);
        baro_pkg::t_out_item r;
        logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, fine, q, pr;
        rt = {12'd0, it.raw_temperature};
        rp = {12'd0, it.raw_pressure};
        r = '0;
        if (rt == 32'd0 || it.raw_temperature == baro_pkg::RAW_SKIP
            || it.raw_pressure == baro_pkg::RAW_SKIP)
            return r;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = sext(cal_temp[31:16]);
        t3 = sext(cal_temp[47:32]);
        p1 = {16'd0, cal_pa[15:0]};
        p2 = sext(cal_pa[31:16]);
        p3 = sext(cal_pa[47:32]);
        p4 = sext(cal_pa[63:48]);
        p5 = sext(cal_pb[15:0]);
        p6 = sext(cal_pb[31:16]);
        p7 = sext(cal_pb[47:32]);
        p8 = sext(cal_pb[63:48]);
        p9 = sext(cal_p9);
        // temperature
        a = asr(((rt >> 3) - (t1 << 1)) * t2, 11);
        b = (rt >> 4) - t1;
        b = asr(asr(b * b, 12) * t3, 14);
        fine = a + b;
        r.temperature_centi = asr(fine * 32'd5 + 32'd128, 8);
        // pressure
        a = asr(fine, 1) - 32'd64000;
        q = asr(a, 2);
        b = asr(q * q, 11) * p6;
        b = b + ((a * p5) << 1);
        b = asr(b, 2) + (p4 << 16);
        a = asr(asr(p3 * asr(q * q, 13), 3) + asr(p2 * a, 1), 18);
        a = asr((32'd32768 + a) * p1, 15);
        if (a == 32'd0) begin
            pr = 32'd0;
        end else begin
            pr = ((32'd1048576 - rp) - asr(b, 12)) * 32'd3125;
            if (pr < 32'h8000_0000) pr = (pr << 1) / a;
            else pr = (pr / a) * 32'd2;
            a = asr(p9 * ((((pr >> 3) * (pr >> 3)) >> 13)), 12);
            b = asr((pr >> 2) * p8, 13);
            pr = pr + asr(a + b + p7, 4);
        end
        r.pressure_pascal = pr;
        r.reading_valid = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    // input driver: after each item, draw the idle gap before the next one
    int in_wait = 0;
    always @(posedge i_clk) begin
        int w;
        if (i_in_valid && !o_in_stall) begin
            expected_q.push_back(compensate(i_in_item));
            void'(reading_q.pop_front());
            w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 14));
            if (w == 0 && reading_q.size() > 0) begin
                i_in_item <= reading_q[0];
            end else begin
                i_in_valid <= 1'b0;
                in_wait <= (w > 0) ? w - 1 : 0;
            end
        end else if (!i_in_valid) begin
            if (in_wait > 0) begin
                in_wait <= in_wait - 1;
            end else if (reading_q.size() > 0 && i_rst_n) begin
                i_in_valid <= 1'b1;
                i_in_item <= reading_q[0];
            end
        end
    end

    // output monitor and stall
    int out_wait = 0;
    always @(posedge i_clk) begin
        baro_pkg::t_out_item exp_item;
        if (o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                exp_item = expected_q.pop_front();
                if (o_out_item.temperature_centi !== exp_item.temperature_centi)
                    report_mismatch($sformatf("temperature %0d exp %0d",
                        o_out_item.temperature_centi, exp_item.temperature_centi));
                if (o_out_item.pressure_pascal !== exp_item.pressure_pascal)
                    report_mismatch($sformatf("pressure %0d exp %0d",
                        o_out_item.pressure_pascal, exp_item.pressure_pascal));
                if (o_out_item.reading_valid !== exp_item.reading_valid)
                    report_mismatch($sformatf("valid %0b exp %0b",
                        o_out_item.reading_valid, exp_item.reading_valid));
            end
            out_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
        end
        if (out_wait > 0) begin
            out_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any accepted item or taken result
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else if (i_rst_n && !stim_done)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("[baro_sensor_compensation_top] ERROR");
            $finish;
        end
    end

    task automatic write_cal(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            baro_pkg::CFG_TEMP:    cal_temp = val[47:0];
            baro_pkg::CFG_PRESS_A: cal_pa = val;
            baro_pkg::CFG_PRESS_B: cal_pb = val;
            baro_pkg::CFG_PRESS_9: cal_p9 = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until the pipeline has drained
    task automatic drain();
        while (reading_q.size() > 0 || i_in_valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    function automatic logic [19:0] rand_raw();
        case ($urandom_range(0, 5))
            0: return 20'd0;
            1: return baro_pkg::RAW_SKIP;
            2: return 20'hFFFFF;
            3: return 20'(400000 + $urandom_range(0, 250000));
            default: return 20'($urandom);
        endcase
    endfunction

    // typical calibration set, keeps the arithmetic in its usual range
    task automatic load_typical();
        write_cal(baro_pkg::CFG_TEMP, {16'hFC18, 16'd26435, 16'd27504});
        write_cal(baro_pkg::CFG_PRESS_A, {16'd2855, 16'd8192, 16'hD6D0, 16'd36477});
        write_cal(baro_pkg::CFG_PRESS_B, {16'hFFF9, 16'hFFF9, 16'd15500, 16'd140});
        write_cal(baro_pkg::CFG_PRESS_9, 64'd6000);
    endtask

    task automatic load_random();
        write_cal(baro_pkg::CFG_TEMP, {$urandom, $urandom});
        write_cal(baro_pkg::CFG_PRESS_A, {$urandom, $urandom});
        write_cal(baro_pkg::CFG_PRESS_B, {$urandom, $urandom});
        write_cal(baro_pkg::CFG_PRESS_9, {$urandom, $urandom});
    endtask

    initial begin
        baro_pkg::t_in_item it;
        cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_p9 = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // zero calibration: divisor is zero
        reading_q.push_back('{20'd519888, 20'd415148});
        reading_q.push_back('{20'd0, 20'd1});
        drain();
        load_typical();
        // field extremes and skipped conversions
        reading_q.push_back('{20'd519888, 20'd415148});
        reading_q.push_back('{20'd1, 20'd0});
        reading_q.push_back('{20'hFFFFF, 20'hFFFFF});
        reading_q.push_back('{20'd0, 20'd300000});
        reading_q.push_back('{baro_pkg::RAW_SKIP, 20'd300000});
        reading_q.push_back('{20'd500000, baro_pkg::RAW_SKIP});
        reading_q.push_back('{20'h7FFFF, 20'h7FFFF});
        reading_q.push_back('{20'h80001, 20'h80001});
        reading_q.push_back('{20'h55555, 20'hAAAAA});
        reading_q.push_back('{20'hAAAAA, 20'h55555});
        drain();
        // extreme calibration words
        write_cal(baro_pkg::CFG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(baro_pkg::CFG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(baro_pkg::CFG_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(baro_pkg::CFG_PRESS_9, 64'hFFFF);
        reading_q.push_back('{20'd519888, 20'd415148});
        reading_q.push_back('{20'hFFFFF, 20'd1});
        drain();
        write_cal(baro_pkg::CFG_TEMP, {16'h8000, 16'h8000, 16'hFFFF});
        write_cal(baro_pkg::CFG_PRESS_A, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
        write_cal(baro_pkg::CFG_PRESS_B, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        write_cal(baro_pkg::CFG_PRESS_9, 64'h8000);
        reading_q.push_back('{20'd1, 20'hFFFFF});
        reading_q.push_back('{20'd600000, 20'd200000});
        drain();
        // random phases over several calibration sets
        for (int ph = 0; ph < 5; ph++) begin
            if (ph % 2 == 0) load_typical();
            else load_random();
            for (int n = 0; n < RAND_ITEMS / 5; n++) begin
                it.raw_temperature = rand_raw();
                it.raw_pressure = rand_raw();
                reading_q.push_back(it);
            end
            drain();
        end
        stim_done = 1'b1;
        if (err_count == 0)
            $display("[baro_sensor_compensation_top] OK");
        else
            $display("[baro_sensor_compensation_top] ERROR");
        $finish;
    end

    // overall simulation time-out
    initial begin
        repeat (2000000) @(posedge i_clk);
        $display("[baro_sensor_compensation_top] ERROR");
        $finish;
    end
endmodule
